/* design/sef_pkg.sv */
// ----------------------------------------------------------------------------
// sef_pkg: shared types, constants and arithmetic for the stereo effect filter
// Holds the mode codes, the command and result records and the per-sample
// math of the high-pass, comb and band-pass effects.
// ----------------------------------------------------------------------------
package sef_pkg;

  localparam int unsigned AVG_TAPS_DEF   = 5;
  localparam int unsigned ECHO_DEPTH_DEF = 4800;

  localparam logic [2:0] MODE_BYPASS   = 3'd0;
  localparam logic [2:0] MODE_LOWPASS  = 3'd1;
  localparam logic [2:0] MODE_HIGHPASS = 3'd2;
  localparam logic [2:0] MODE_REVERB   = 3'd3;
  localparam logic [2:0] MODE_BANDPASS = 3'd4;

  typedef enum logic [2:0] {
    OP_BYPASS,
    OP_AVG,
    OP_HP,
    OP_COMB,
    OP_BQ
  } sef_op_e;

  typedef struct packed {
    sef_op_e            op;
    logic signed [15:0] left;
    logic signed [15:0] right;
  } sef_cmd_t;

  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] right;
  } sef_res_t;

  typedef struct packed {
    logic signed [31:0] y;
    logic signed [15:0] out;
  } sef_bq_t;

  // high-pass gain 950/1024
  localparam logic signed [11:0] HP_NUM   = 12'sd950;
  localparam int unsigned        HP_SHIFT = 10;

  // comb gain 35/100 = 7/20, as a reciprocal multiply exact for 16-bit magnitudes
  localparam logic [22:0]  COMB_RECIP = 23'd5872026;
  localparam int unsigned  COMB_SHIFT = 24;

  // band-pass coefficients, Q2.30
  localparam logic signed [63:0] BQ_B0 = 64'sd116694205;
  localparam logic signed [63:0] BQ_A1 = -64'sd1877316435;
  localparam logic signed [63:0] BQ_A2 = 64'sd840353414;

  function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
    if (v > 64'sd32767) begin
      return 16'sh7FFF;
    end else if (v < -64'sd32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  function automatic logic signed [15:0] hp_calc(input logic signed [15:0] x,
                                                 input logic signed [15:0] li,
                                                 input logic signed [15:0] lo);
    logic signed [17:0] t;
    logic signed [28:0] p;
    logic signed [28:0] q;
    t = 18'(lo) + 18'(x) - 18'(li);
    p = 29'(t) * 29'(HP_NUM);
    q = p[28] ? p + 29'sd1023 : p;
    q = q >>> HP_SHIFT;
    return sat16(64'(q));
  endfunction

  function automatic logic signed [15:0] comb_calc(input logic signed [15:0] x,
                                                   input logic signed [15:0] d);
    logic [15:0]        m;
    logic [38:0]        prod;
    logic [14:0]        mag;
    logic signed [17:0] q;
    logic signed [17:0] y;
    m    = d[15] ? 16'(-d) : 16'(d);
    prod = 39'(m) * 39'(COMB_RECIP);
    mag  = prod[COMB_SHIFT +: 15];
    q    = d[15] ? -$signed(18'(mag)) : $signed(18'(mag));
    y    = 18'(x) + q;
    return sat16(64'(y));
  endfunction

  function automatic sef_bq_t bq_calc(input logic signed [15:0] x,
                                      input logic signed [15:0] x2,
                                      input logic signed [31:0] y1,
                                      input logic signed [31:0] y2);
    logic signed [63:0] dx;
    logic signed [63:0] acc;
    logic signed [63:0] yw;
    logic signed [63:0] ow;
    sef_bq_t            r;
    dx  = 64'(x) - 64'(x2);
    acc = ((BQ_B0 * dx) <<< 14) - (BQ_A1 * 64'(y1)) - (BQ_A2 * 64'(y2));
    // truncate toward zero
    yw  = acc[63] ? acc + 64'sd1073741823 : acc;
    yw  = yw >>> 30;
    if (yw > 64'sd2147483647) begin
      r.y = 32'sh7FFFFFFF;
    end else if (yw < -64'sd2147483648) begin
      r.y = 32'sh80000000;
    end else begin
      r.y = yw[31:0];
    end
    ow    = 64'(r.y);
    ow    = ow[63] ? ow + 64'sd16383 : ow;
    ow    = ow >>> 14;
    r.out = sat16(ow);
    return r;
  endfunction

endpackage

/* design/sef_fifo.sv */
// ----------------------------------------------------------------------------
// sef_fifo: two-entry queue
// Full rate with simultaneous push and pop; full and empty come from a count.
// ----------------------------------------------------------------------------
module sef_fifo #(
  parameter int unsigned WIDTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + 2'd1;
      2'b01:   count_d = count_q - 2'd1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

/* design/sef_front.sv */
// ----------------------------------------------------------------------------
// sef_front: input side
// Holds the mode register, tags each accepted pair with its effect and
// signals a state clear on every mode write.
// ----------------------------------------------------------------------------
module sef_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  logic signed [15:0] left_sample_i,
  input  logic signed [15:0] right_sample_i,
  input  logic               cfg_valid_i,
  input  logic [2:0]         cfg_data_i,
  output logic               cfg_ready_o,
  input  logic               q_full_i,
  output logic               q_push_o,
  output sef_pkg::sef_cmd_t  cmd_o,
  output logic               clear_o
);

  logic [2:0]       mode_q;
  sef_pkg::sef_op_e op;

  assign cfg_ready_o = 1'b1;
  assign clear_o     = cfg_valid_i;
  assign q_push_o    = push_i & ~q_full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= sef_pkg::MODE_BYPASS;
    end else if (cfg_valid_i) begin
      mode_q <= cfg_data_i;
    end
  end

  // unused codes fall back to bypass
  always_comb begin
    case (mode_q)
      sef_pkg::MODE_LOWPASS:  op = sef_pkg::OP_AVG;
      sef_pkg::MODE_HIGHPASS: op = sef_pkg::OP_HP;
      sef_pkg::MODE_REVERB:   op = sef_pkg::OP_COMB;
      sef_pkg::MODE_BANDPASS: op = sef_pkg::OP_BQ;
      default:                op = sef_pkg::OP_BYPASS;
    endcase
  end

  assign cmd_o.op    = op;
  assign cmd_o.left  = left_sample_i;
  assign cmd_o.right = right_sample_i;

endmodule

/* design/sef_back.sv */
// ----------------------------------------------------------------------------
// sef_back: effect engine
// Executes one queued pair per cycle, while the result queue has room, against
// filter state and echo memory; the next slot's echo read is registered ahead.
// ----------------------------------------------------------------------------
module sef_back #(
  parameter int unsigned AVG_TAPS   = sef_pkg::AVG_TAPS_DEF,
  parameter int unsigned ECHO_DEPTH = sef_pkg::ECHO_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              clear_i,
  input  logic              cmd_empty_i,
  input  sef_pkg::sef_cmd_t cmd_i,
  output logic              cmd_pop_o,
  input  logic              res_full_i,
  output logic              res_push_o,
  output sef_pkg::sef_res_t res_o
);

  localparam int unsigned AW        = (AVG_TAPS > 1) ? $clog2(AVG_TAPS) : 1;
  localparam int unsigned EW        = (ECHO_DEPTH > 1) ? $clog2(ECHO_DEPTH) : 1;
  localparam int unsigned SW        = 17 + $clog2(AVG_TAPS);
  localparam int unsigned AVG_SHIFT = SW + 5;
  localparam int unsigned PW        = SW + AVG_SHIFT + 1;
  localparam logic [AVG_SHIFT:0] AVG_RECIP =
    (AVG_SHIFT+1)'(((64'd1 << AVG_SHIFT) + 64'(AVG_TAPS) - 64'd1) / 64'(AVG_TAPS));

  logic fire, avg_fire, hp_fire, comb_fire, bq_fire;

  logic signed [15:0] win_q   [2][AVG_TAPS];
  logic signed [SW-1:0] sum_q [2];
  logic signed [SW-1:0] sum_d [2];
  logic [AW-1:0]      avg_pos_q, avg_nxt;
  logic signed [15:0] hp_in_q  [2];
  logic signed [15:0] hp_out_q [2];
  logic signed [15:0] bq_x1_q  [2];
  logic signed [15:0] bq_x2_q  [2];
  logic signed [31:0] bq_y1_q  [2];
  logic signed [31:0] bq_y2_q  [2];
  logic [EW-1:0]      echo_pos_q, echo_nxt, echo_raddr;
  logic               wrapped_q;
  logic [31:0]        echo_mem [ECHO_DEPTH];
  logic [31:0]        echo_rd_q;
  logic [31:0]        echo_wdata;

  logic signed [15:0] x      [2];
  logic signed [15:0] y      [2];
  logic signed [15:0] hp_y   [2];
  logic signed [15:0] cb_y   [2];
  logic signed [15:0] dly    [2];
  sef_pkg::sef_bq_t   bq_r   [2];
  logic signed [15:0] avg_y  [2];

  assign fire       = ~cmd_empty_i & ~res_full_i;
  assign cmd_pop_o  = fire;
  assign res_push_o = fire;
  assign avg_fire   = fire && (cmd_i.op == sef_pkg::OP_AVG);
  assign hp_fire    = fire && (cmd_i.op == sef_pkg::OP_HP);
  assign comb_fire  = fire && (cmd_i.op == sef_pkg::OP_COMB);
  assign bq_fire    = fire && (cmd_i.op == sef_pkg::OP_BQ);

  assign avg_nxt  = (avg_pos_q == AW'(AVG_TAPS - 1)) ? '0 : avg_pos_q + 1'b1;
  assign echo_nxt = (echo_pos_q == EW'(ECHO_DEPTH - 1)) ? '0 : echo_pos_q + 1'b1;
  assign echo_raddr = clear_i ? '0 : (comb_fire ? echo_nxt : echo_pos_q);

  assign x[0]   = cmd_i.left;
  assign x[1]   = cmd_i.right;
  // slots not yet written since the last clear read as zero
  assign dly[0] = wrapped_q ? echo_rd_q[31:16] : 16'sd0;
  assign dly[1] = wrapped_q ? echo_rd_q[15:0]  : 16'sd0;

  always_comb begin
    logic              neg;
    logic [SW-1:0]     mag;
    logic [PW-1:0]     prod;
    logic [16:0]       qm;
    logic signed [17:0] avg;
    for (int ch = 0; ch < 2; ch++) begin
      sum_d[ch] = sum_q[ch] + SW'(x[ch]) - SW'(win_q[ch][avg_pos_q]);
      neg       = sum_d[ch][SW-1];
      mag       = neg ? SW'(-sum_d[ch]) : SW'(sum_d[ch]);
      prod      = PW'(mag) * PW'(AVG_RECIP);
      qm        = prod[AVG_SHIFT +: 17];
      avg       = neg ? -$signed(18'(qm)) : $signed(18'(qm));
      avg_y[ch] = avg[15:0];
      hp_y[ch]  = sef_pkg::hp_calc(x[ch], hp_in_q[ch], hp_out_q[ch]);
      cb_y[ch]  = sef_pkg::comb_calc(x[ch], dly[ch]);
      bq_r[ch]  = sef_pkg::bq_calc(x[ch], bq_x2_q[ch], bq_y1_q[ch], bq_y2_q[ch]);
      case (cmd_i.op)
        sef_pkg::OP_AVG:  y[ch] = avg_y[ch];
        sef_pkg::OP_HP:   y[ch] = hp_y[ch];
        sef_pkg::OP_COMB: y[ch] = cb_y[ch];
        sef_pkg::OP_BQ:   y[ch] = bq_r[ch].out;
        default:          y[ch] = x[ch];
      endcase
    end
  end

  assign res_o.left  = y[0];
  assign res_o.right = y[1];
  assign echo_wdata  = {cb_y[0], cb_y[1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avg_pos_q  <= '0;
      echo_pos_q <= '0;
      wrapped_q  <= 1'b0;
      for (int ch = 0; ch < 2; ch++) begin
        sum_q[ch]    <= '0;
        hp_in_q[ch]  <= '0;
        hp_out_q[ch] <= '0;
        bq_x1_q[ch]  <= '0;
        bq_x2_q[ch]  <= '0;
        bq_y1_q[ch]  <= '0;
        bq_y2_q[ch]  <= '0;
        for (int i = 0; i < AVG_TAPS; i++) begin
          win_q[ch][i] <= '0;
        end
      end
    end else if (clear_i) begin
      avg_pos_q  <= '0;
      echo_pos_q <= '0;
      wrapped_q  <= 1'b0;
      for (int ch = 0; ch < 2; ch++) begin
        sum_q[ch]    <= '0;
        hp_in_q[ch]  <= '0;
        hp_out_q[ch] <= '0;
        bq_x1_q[ch]  <= '0;
        bq_x2_q[ch]  <= '0;
        bq_y1_q[ch]  <= '0;
        bq_y2_q[ch]  <= '0;
        for (int i = 0; i < AVG_TAPS; i++) begin
          win_q[ch][i] <= '0;
        end
      end
    end else begin
      if (avg_fire) begin
        avg_pos_q <= avg_nxt;
        for (int ch = 0; ch < 2; ch++) begin
          sum_q[ch]            <= sum_d[ch];
          win_q[ch][avg_pos_q] <= x[ch];
        end
      end
      if (hp_fire) begin
        for (int ch = 0; ch < 2; ch++) begin
          hp_in_q[ch]  <= x[ch];
          hp_out_q[ch] <= hp_y[ch];
        end
      end
      if (comb_fire) begin
        echo_pos_q <= echo_nxt;
        if (echo_pos_q == EW'(ECHO_DEPTH - 1)) begin
          wrapped_q <= 1'b1;
        end
      end
      if (bq_fire) begin
        for (int ch = 0; ch < 2; ch++) begin
          bq_x2_q[ch] <= bq_x1_q[ch];
          bq_x1_q[ch] <= x[ch];
          bq_y2_q[ch] <= bq_y1_q[ch];
          bq_y1_q[ch] <= bq_r[ch].y;
        end
      end
    end
  end

  // echo memory: write the clipped result back, read the next slot ahead
  always_ff @(posedge clk_i) begin
    if (comb_fire) begin
      echo_mem[echo_pos_q] <= echo_wdata;
    end
    if (comb_fire && (echo_pos_q == echo_raddr)) begin
      echo_rd_q <= echo_wdata;
    end else begin
      echo_rd_q <= echo_mem[echo_raddr];
    end
  end

endmodule

/* design/stereo_audio_effect_filter.sv */
// ----------------------------------------------------------------------------
// stereo_audio_effect_filter: selectable stereo effect (bypass, moving
// average, high-pass, comb reverb, band-pass biquad)
//
// Input queue: a pair is taken on push while full is low. Result queue: the
// oldest filtered pair sits on left_out_o/right_out_o while empty is low and
// leaves on pop. Mode register: written through cfg_valid_i/cfg_ready_o
// (ready is always high); each write also clears all filter state. Write it
// only while no pair is in flight.
// A pushed pair passes through the command queue and the effect engine, which
// is combinational, into the result queue. Throughput: one pair per cycle while
// the result side keeps popping, set by the effect engine and the echo memory,
// whose read for the next slot is registered ahead of its use.
// A stalled result side fills the two-entry result queue, then the two-entry
// command queue, after which full goes high; nothing is dropped.
// Reset clears the mode to bypass and all state; the echo memory needs no
// clearing pass since slots not yet written since the clear read as zero.
// ----------------------------------------------------------------------------
module stereo_audio_effect_filter #(
  parameter int unsigned AVG_TAPS   = sef_pkg::AVG_TAPS_DEF,
  parameter int unsigned ECHO_DEPTH = sef_pkg::ECHO_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic signed [15:0] left_sample_i,
  input  logic signed [15:0] right_sample_i,
  output logic               empty,
  input  logic               pop,
  output logic signed [15:0] left_out_o,
  output logic signed [15:0] right_out_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_data_i
);

  localparam int unsigned CW = $bits(sef_pkg::sef_cmd_t);
  localparam int unsigned RW = $bits(sef_pkg::sef_res_t);

  sef_pkg::sef_cmd_t cmd_in, cmd_head;
  sef_pkg::sef_res_t res_in, res_head;
  logic              q_push, q_full, q_pop, q_empty;
  logic              r_push, r_full;
  logic              clear;
  logic [CW-1:0]     cmd_head_bits;
  logic [RW-1:0]     res_head_bits;

  sef_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .left_sample_i  (left_sample_i),
    .right_sample_i (right_sample_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_data_i     (cfg_data_i),
    .cfg_ready_o    (cfg_ready_o),
    .q_full_i       (q_full),
    .q_push_o       (q_push),
    .cmd_o          (cmd_in),
    .clear_o        (clear)
  );

  sef_fifo #(.WIDTH(CW)) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (cmd_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (cmd_head_bits),
    .empty_o (q_empty)
  );

  assign cmd_head = sef_pkg::sef_cmd_t'(cmd_head_bits);
  assign full     = q_full;

  sef_back #(
    .AVG_TAPS   (AVG_TAPS),
    .ECHO_DEPTH (ECHO_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clear_i     (clear),
    .cmd_empty_i (q_empty),
    .cmd_i       (cmd_head),
    .cmd_pop_o   (q_pop),
    .res_full_i  (r_full),
    .res_push_o  (r_push),
    .res_o       (res_in)
  );

  sef_fifo #(.WIDTH(RW)) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (r_push),
    .data_i  (res_in),
    .full_o  (r_full),
    .pop_i   (pop),
    .data_o  (res_head_bits),
    .empty_o (empty)
  );

  assign res_head    = sef_pkg::sef_res_t'(res_head_bits);
  assign left_out_o  = res_head.left;
  assign right_out_o = res_head.right;

endmodule

/* bench/filter_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// filter_checker: result predictor and comparator for the stereo effect filter
// Follows pair and mode transfers, computes each expected output pair and
// checks it against the popped results in order.
// ----------------------------------------------------------------------------
module filter_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  logic               full_i,
  input  logic signed [15:0] left_sample_i,
  input  logic signed [15:0] right_sample_i,
  input  logic               empty_i,
  input  logic               pop_i,
  input  logic signed [15:0] left_out_i,
  input  logic signed [15:0] right_out_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [2:0]         cfg_data_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  localparam int TAPS  = sef_pkg::AVG_TAPS_DEF;
  localparam int DEPTH = sef_pkg::ECHO_DEPTH_DEF;

  logic [2:0]         mode_q;
  logic signed [15:0] win_l [TAPS];
  logic signed [15:0] win_r [TAPS];
  int                 win_pos;
  logic signed [15:0] hp_in [2];
  logic signed [15:0] hp_out [2];
  logic signed [15:0] echo_l [DEPTH];
  logic signed [15:0] echo_r [DEPTH];
  int                 echo_pos;
  logic signed [15:0] bq_x [4];
  longint             bq_y [4];
  sef_pkg::sef_res_t  pair_q [$];

  function automatic logic signed [15:0] clip16(longint v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return 16'(v);
  endfunction

  task automatic clear_all();
    for (int i = 0; i < TAPS; i++) begin
      win_l[i] = '0;
      win_r[i] = '0;
    end
    for (int i = 0; i < DEPTH; i++) begin
      echo_l[i] = '0;
      echo_r[i] = '0;
    end
    for (int i = 0; i < 2; i++) begin
      hp_in[i] = '0;
      hp_out[i] = '0;
    end
    for (int i = 0; i < 4; i++) begin
      bq_x[i] = '0;
      bq_y[i] = 0;
    end
    win_pos = 0;
    echo_pos = 0;
  endtask

  // SV division truncates toward zero, same as the intended arithmetic
  function automatic logic signed [15:0] avg_of(ref logic signed [15:0] w [TAPS]);
    longint acc;
    acc = 0;
    for (int i = 0; i < TAPS; i++) acc += w[i];
    return clip16(acc / TAPS);
  endfunction

  function automatic logic signed [15:0] hp_step(int ch, logic signed [15:0] x);
    longint y;
    y = (longint'(hp_out[ch]) + x - hp_in[ch]) * 950 / 1024;
    hp_in[ch] = x;
    hp_out[ch] = clip16(y);
    return hp_out[ch];
  endfunction

  function automatic logic signed [15:0] comb_step(logic signed [15:0] x,
                                                   logic signed [15:0] d);
    return clip16(longint'(x) + longint'(d) * 35 / 100);
  endfunction

  function automatic logic signed [15:0] bq_step(int ch, logic signed [15:0] x);
    int     k;
    longint acc;
    longint y;
    k = ch * 2;
    acc = 64'sd116694205 * (longint'(x) - bq_x[k + 1]) * 16384
          + 64'sd1877316435 * bq_y[k] - 64'sd840353414 * bq_y[k + 1];
    y = acc / 64'sd1073741824;
    if (y > 64'sd2147483647) y = 64'sd2147483647;
    if (y < -64'sd2147483648) y = -64'sd2147483648;
    bq_x[k + 1] = bq_x[k];
    bq_x[k] = x;
    bq_y[k + 1] = bq_y[k];
    bq_y[k] = y;
    return clip16(y / 16384);
  endfunction

  function automatic sef_pkg::sef_res_t filter_pair(logic signed [15:0] l,
                                                    logic signed [15:0] r);
    sef_pkg::sef_res_t res;
    case (mode_q)
      sef_pkg::MODE_LOWPASS: begin
        win_l[win_pos] = l;
        win_r[win_pos] = r;
        res.left = avg_of(win_l);
        res.right = avg_of(win_r);
        win_pos = (win_pos + 1) % TAPS;
      end
      sef_pkg::MODE_HIGHPASS: begin
        res.left = hp_step(0, l);
        res.right = hp_step(1, r);
      end
      sef_pkg::MODE_REVERB: begin
        res.left = comb_step(l, echo_l[echo_pos]);
        res.right = comb_step(r, echo_r[echo_pos]);
        echo_l[echo_pos] = res.left;
        echo_r[echo_pos] = res.right;
        echo_pos = (echo_pos + 1) % DEPTH;
      end
      sef_pkg::MODE_BANDPASS: begin
        res.left = bq_step(0, l);
        res.right = bq_step(1, r);
      end
      default: begin
        res.left = l;
        res.right = r;
      end
    endcase
    return res;
  endfunction

  assign pending_o = pair_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    sef_pkg::sef_res_t want;
    if (!rst_ni) begin
      mode_q <= sef_pkg::MODE_BYPASS;
      clear_all();
      pair_q.delete();
      fail_count_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        mode_q <= cfg_data_i;
        clear_all();
      end
      if (push_i && !full_i) pair_q.push_back(filter_pair(left_sample_i, right_sample_i));
      if (pop_i && !empty_i) begin
        if (pair_q.size() == 0) begin
          $error("unexpected result %0d %0d", left_out_i, right_out_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = pair_q.pop_front();
          if (want.left !== left_out_i) begin
            $error("left_out: expected %0d, got %0d", want.left, left_out_i);
            fail_count_o <= fail_count_o + 1;
          end else if (want.right !== right_out_i) begin
            $error("right_out: expected %0d, got %0d", want.right, right_out_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end
endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus for the stereo effect filter
// Walks through every mode with directed extremes and random pairs under
// random push/pop gaps; the checker module judges every result.
// ----------------------------------------------------------------------------
module testbench;

  logic               clk_i = 0;
  logic               rst_ni = 0;
  logic               push = 0;
  logic               full;
  logic signed [15:0] left_sample_i = 0;
  logic signed [15:0] right_sample_i = 0;
  logic               empty;
  logic               pop = 0;
  logic signed [15:0] left_out_o;
  logic signed [15:0] right_out_o;
  logic               cfg_valid_i = 0;
  logic               cfg_ready_o;
  logic [2:0]         cfg_data_i = 0;
  int                 fail_count;
  int                 pending;
  int                 cycle_count = 0;
  bit                 calm = 0;

  always begin
    #2 clk_i = 1;
    #2 clk_i = 0;
  end

  stereo_audio_effect_filter u_top (.*);

  filter_checker u_chk (
    .clk_i, .rst_ni, .push_i(push), .full_i(full), .left_sample_i, .right_sample_i,
    .empty_i(empty), .pop_i(pop), .left_out_i(left_out_o), .right_out_i(right_out_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result side: random pop stall bursts
  initial begin
    int gap;
    forever begin
      @(negedge clk_i);
      if (!calm && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 13);
        pop <= 0;
        repeat (gap) @(negedge clk_i);
      end
      pop <= 1;
    end
  end

  // push stays high across back-to-back pairs; it drops only for idle bursts
  task automatic send_pair(logic signed [15:0] l, logic signed [15:0] r);
    int gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 13);
      push <= 0;
      repeat (gap) @(negedge clk_i);
    end
    push <= 1;
    left_sample_i <= l;
    right_sample_i <= r;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain();
    push <= 0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_mode(logic [2:0] m);
    drain();
    cfg_valid_i <= 1;
    cfg_data_i <= m;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 0;
  endtask

  function automatic logic signed [15:0] rnd_sample();
    case ($urandom_range(0, 4))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'($signed($urandom_range(0, 200)) - 100);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [2:0] modes [8];
    modes = '{sef_pkg::MODE_BYPASS, sef_pkg::MODE_LOWPASS, sef_pkg::MODE_HIGHPASS,
              sef_pkg::MODE_REVERB, sef_pkg::MODE_BANDPASS, 3'd5, 3'd6, 3'd7};
    repeat (8) @(negedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);
    // directed: extremes through every mode, bypass right after reset
    foreach (modes[i]) begin
      if (i != 0) set_mode(modes[i]);
      send_pair(16'sh7FFF, 16'sh8000);
      send_pair(16'sh8000, 16'sh7FFF);
      send_pair(16'sh7FFF, 16'sh7FFF);
      send_pair(0, -1);
    end
    // long reverb run
    set_mode(sef_pkg::MODE_REVERB);
    for (int n = 0; n < 1000; n++) send_pair(rnd_sample(), rnd_sample());
    // sender holds until all results are back, then resumes in the same mode
    drain();
    for (int n = 0; n < 30; n++) send_pair(rnd_sample(), rnd_sample());
    for (int p = 0; p < 20; p++) begin
      if (p == 16) calm = 1;
      set_mode(3'($urandom_range(0, 7)));
      for (int n = 0; n < 40; n++) send_pair(rnd_sample(), rnd_sample());
    end
    set_mode(sef_pkg::MODE_BANDPASS);
    for (int n = 0; n < 200; n++) send_pair(16'sh7FFF, 16'sh8000);
    drain();
    repeat (10) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
